// File: src/rtd_c2t_pkg.sv
// shared types, constants and coefficient tables for the rtd code to temperature block
`default_nettype none
package rtd_c2t_pkg;

  localparam int CODE_BITS     = 15;
  localparam int FRACTION_BITS = 8;
  localparam int REG_W         = 16;
  localparam int TEMP_W        = 19;

  localparam int XQ_FRAC    = 32;
  localparam int XQ_W       = XQ_FRAC + 3;
  localparam int P_W        = CODE_BITS + REG_W;
  localparam int DIV1_HI_W  = P_W - CODE_BITS - 3;
  localparam int DIV1_STEPS = XQ_W;
  localparam int SQRT_STEPS = 25;
  localparam int DIV2_STEPS = TEMP_W - 1;
  localparam int POLY_STEPS = 5;
  localparam int POLY_Q     = 24;

  localparam int REM_W   = 27;
  localparam int LOW_W   = 2 * SQRT_STEPS;
  localparam int ROOT_W  = XQ_W;
  localparam int DEN_W   = 26;
  localparam int ACC_W   = 36;
  localparam int CVD_B_W = 28;
  localparam int PROD_W  = XQ_W + CVD_B_W;
  localparam int BD_SHIFT = 14;
  localparam int BD_W    = PROD_W - BD_SHIFT;
  localparam int NUM_W   = XQ_W + FRACTION_BITS + 2;
  localparam int POLY_SHIFT = POLY_Q - FRACTION_BITS;

  localparam logic [REG_W-1:0] NOMINAL_RESET   = REG_W'(100);
  localparam logic [REG_W-1:0] REFERENCE_RESET = REG_W'(430);

  localparam logic REG_NOMINAL   = 1'b0;
  localparam logic REG_REFERENCE = 1'b1;

  localparam logic [DEN_W-1:0]   CVD_A_Q32  = DEN_W'(16786021);
  localparam logic [CVD_B_W-1:0] CVD_4B_Q46 = CVD_B_W'(162551799);
  localparam logic [BD_W-1:0]    CVD_A2     = BD_W'(64'd16786021 * 64'd16786021);
  localparam logic [XQ_W-1:0]    ONE_Q32    = XQ_W'(64'd1 << XQ_FRAC);

  localparam logic signed [ACC_W-1:0] POLY_COEF [POLY_STEPS+1] = '{
    -36'sd4060421816,
     36'sd3729239572,
     36'sd433842029,
    -36'sd80966844,
    -36'sd47283228,
     36'sd25573510
  };

  localparam logic signed [ACC_W-1:0] POLY_RND = ACC_W'(64'd1 << (POLY_SHIFT - 1));

  localparam logic signed [TEMP_W-1:0] TEMP_MAX = TEMP_W'(262143);
  localparam logic signed [TEMP_W-1:0] TEMP_MIN = -TEMP_W'(65536);
  localparam logic signed [ACC_W-1:0]  TEMP_MAX_W = ACC_W'(262143);
  localparam logic signed [ACC_W-1:0]  TEMP_MIN_W = -ACC_W'(65536);

  typedef struct packed {
    logic                    pos;
    logic                    ovf;
    logic [XQ_W-1:0]         xq;
    logic [REM_W-1:0]        rem;
    logic [LOW_W-1:0]        low;
    logic [ROOT_W-1:0]       root;
    logic [DEN_W-1:0]        den;
    logic signed [ACC_W-1:0] acc;
  } c2t_item_t;

endpackage
`default_nettype wire

// File: src/rtd_in_if.sv
// request channel carrying one converter code
`default_nettype none
interface rtd_in_if import rtd_c2t_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CODE_BITS-1:0] rtd_code;

  modport source (output valid, output rtd_code, input ready);
  modport sink (input valid, input rtd_code, output ready);
endinterface
`default_nettype wire

// File: src/rtd_out_if.sv
// request channel carrying one temperature result
`default_nettype none
interface rtd_out_if import rtd_c2t_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] temperature;
  logic                     range_error;

  modport source (output valid, output temperature, output range_error, input ready);
  modport sink (input valid, input temperature, input range_error, output ready);
endinterface
`default_nettype wire

// File: src/rtd_code_to_temperature.sv
// top level: rtd ratio code to temperature, pipelined chain of arithmetic cells
//
// Takes one converter code per cycle and returns one temperature per code, in order. The
// chain is 1 multiply + 1 setup + 35 divide cells + 1 setup + 5 polynomial cells + 1 multiply
// + 1 setup + 25 square-root cells + 2 setup + 18 divide cells + 1 output register.
// Throughput is one code per cycle; the whole chain advances together and holds only while a
// result waits at the output and the last cell is full. Registers: nominal resistance at byte 0,
// reference resistance at byte 4.
`default_nettype none
module rtd_code_to_temperature import rtd_c2t_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  rtd_in_if.sink           in_req,
  rtd_out_if.source        out_req,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [REG_W-1:0] nominal_r;
  logic [REG_W-1:0] reference_r;
  logic [REG_W-1:0] r0;
  logic             wr;

  logic      en;
  logic      mul_v_r, dset_v_r, pset_v_r, bd_v_r, rset_v_r, den_v_r, nset_v_r;
  c2t_item_t mul_r, dset_r, pset_r, bd_r, rset_r, den_r, nset_r;
  c2t_item_t mul_nxt, dset_nxt, pset_nxt, bd_nxt, rset_nxt, den_nxt, nset_nxt;

  logic      d1_v [DIV1_STEPS+1];
  c2t_item_t d1_item [DIV1_STEPS+1];
  logic      hn_v [POLY_STEPS+1];
  c2t_item_t hn_item [POLY_STEPS+1];
  logic      sq_v [SQRT_STEPS+1];
  c2t_item_t sq_item [SQRT_STEPS+1];
  logic      d2_v [DIV2_STEPS+1];
  c2t_item_t d2_item [DIV2_STEPS+1];

  logic                     out_valid_r;
  logic signed [TEMP_W-1:0] out_temp_r, out_temp_nxt;
  logic                     out_err_r, out_err_nxt;

  logic [P_W-1:0]       p;
  logic [DIV1_HI_W-1:0] p_hi;
  logic [XQ_W-1:0]      d_bd, d_n;
  logic [PROD_W-1:0]    bd_prod;
  logic [BD_W-1:0]      bd;
  logic [NUM_W-1:0]     num, lim;
  logic signed [ACC_W-1:0] rounded, t_full;
  logic                 last_v;
  c2t_item_t            last;

  // configuration
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign r0     = (nominal_r == '0) ? REG_W'(1) : nominal_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nominal_r   <= NOMINAL_RESET;
      reference_r <= REFERENCE_RESET;
    end else if (wr) begin
      unique case (paddr[2])
        REG_NOMINAL:   nominal_r   <= pwdata[REG_W-1:0];
        REG_REFERENCE: reference_r <= pwdata[REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_NOMINAL:   prdata = 32'(nominal_r);
      REG_REFERENCE: prdata = 32'(reference_r);
      default:       prdata = '0;
    endcase
  end

  // chain advance
  assign last_v = d2_v[DIV2_STEPS];
  assign last   = d2_item[DIV2_STEPS];
  assign en     = !out_valid_r || out_req.ready || !last_v;
  assign in_req.ready = en;

  // setup stages between cell rows
  always_comb begin
    mul_nxt    = '0;
    mul_nxt.xq = XQ_W'(P_W'(in_req.rtd_code) * P_W'(reference_r));

    p    = mul_r.xq[P_W-1:0];
    p_hi = p[P_W-1:CODE_BITS+3];
    dset_nxt      = '0;
    dset_nxt.ovf  = REG_W'(p_hi) >= r0;
    dset_nxt.rem  = REM_W'(p_hi);
    dset_nxt.den  = DEN_W'(r0);
    dset_nxt.low  = {p[CODE_BITS+2:0], (LOW_W-CODE_BITS-3)'(0)};

    pset_nxt     = d1_item[DIV1_STEPS];
    pset_nxt.xq  = d1_item[DIV1_STEPS].root[XQ_W-1:0];
    pset_nxt.pos = d1_item[DIV1_STEPS].ovf || (|d1_item[DIV1_STEPS].root[XQ_W-1:XQ_FRAC]);
    pset_nxt.acc = POLY_COEF[POLY_STEPS];

    d_bd    = hn_item[POLY_STEPS].xq - ONE_Q32;
    bd_prod = PROD_W'(d_bd) * PROD_W'(CVD_4B_Q46);
    bd_nxt     = hn_item[POLY_STEPS];
    bd_nxt.low = LOW_W'(bd_prod >> BD_SHIFT);

    bd = bd_r.low[BD_W-1:0];
    rset_nxt      = bd_r;
    rset_nxt.ovf  = bd_r.ovf || (bd > CVD_A2);
    rset_nxt.low  = LOW_W'(CVD_A2 - bd);
    rset_nxt.rem  = '0;
    rset_nxt.root = '0;

    den_nxt     = sq_item[SQRT_STEPS];
    den_nxt.den = CVD_A_Q32 + DEN_W'(sq_item[SQRT_STEPS].root[SQRT_STEPS-1:0]);

    d_n = den_r.xq - ONE_Q32;
    num = (NUM_W'(d_n) << (FRACTION_BITS + 1)) + NUM_W'(den_r.den >> 1);
    lim = NUM_W'(den_r.den) << DIV2_STEPS;
    nset_nxt      = den_r;
    nset_nxt.ovf  = den_r.ovf || (num >= lim);
    nset_nxt.rem  = REM_W'(num >> DIV2_STEPS);
    nset_nxt.low  = {num[DIV2_STEPS-1:0], (LOW_W-DIV2_STEPS)'(0)};
    nset_nxt.root = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_v_r  <= 1'b0;
      dset_v_r <= 1'b0;
      pset_v_r <= 1'b0;
      bd_v_r   <= 1'b0;
      rset_v_r <= 1'b0;
      den_v_r  <= 1'b0;
      nset_v_r <= 1'b0;
    end else if (en) begin
      mul_v_r  <= in_req.valid;
      dset_v_r <= mul_v_r;
      pset_v_r <= d1_v[DIV1_STEPS];
      bd_v_r   <= hn_v[POLY_STEPS];
      rset_v_r <= bd_v_r;
      den_v_r  <= sq_v[SQRT_STEPS];
      nset_v_r <= den_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mul_r  <= mul_nxt;
      dset_r <= dset_nxt;
      pset_r <= pset_nxt;
      bd_r   <= bd_nxt;
      rset_r <= rset_nxt;
      den_r  <= den_nxt;
      nset_r <= nset_nxt;
    end
  end

  // cell rows
  assign d1_v[0]    = dset_v_r;
  assign d1_item[0] = dset_r;
  assign hn_v[0]    = pset_v_r;
  assign hn_item[0] = pset_r;
  assign sq_v[0]    = rset_v_r;
  assign sq_item[0] = rset_r;
  assign d2_v[0]    = nset_v_r;
  assign d2_item[0] = nset_r;

  for (genvar i = 0; i < DIV1_STEPS; i++) begin : g_div1
    rtd_c2t_div_cell u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .in_valid(d1_v[i]), .in_item(d1_item[i]),
      .out_valid(d1_v[i+1]), .out_item(d1_item[i+1])
    );
  end

  for (genvar i = 0; i < POLY_STEPS; i++) begin : g_poly
    rtd_c2t_horner_cell u_cell (
      .clk(clk), .rst_n(rst_n), .en(en), .coef(POLY_COEF[POLY_STEPS-1-i]),
      .in_valid(hn_v[i]), .in_item(hn_item[i]),
      .out_valid(hn_v[i+1]), .out_item(hn_item[i+1])
    );
  end

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
    rtd_c2t_sqrt_cell u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .in_valid(sq_v[i]), .in_item(sq_item[i]),
      .out_valid(sq_v[i+1]), .out_item(sq_item[i+1])
    );
  end

  for (genvar i = 0; i < DIV2_STEPS; i++) begin : g_div2
    rtd_c2t_div_cell u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .in_valid(d2_v[i]), .in_item(d2_item[i]),
      .out_valid(d2_v[i+1]), .out_item(d2_item[i+1])
    );
  end

  // result select and saturation
  always_comb begin
    rounded      = last.acc + POLY_RND;
    t_full       = rounded >>> POLY_SHIFT;
    out_temp_nxt = TEMP_MAX;
    out_err_nxt  = 1'b0;
    if (!last.pos) begin
      if (t_full > TEMP_MAX_W) begin
        out_temp_nxt = TEMP_MAX;
        out_err_nxt  = 1'b1;
      end else if (t_full < TEMP_MIN_W) begin
        out_temp_nxt = TEMP_MIN;
        out_err_nxt  = 1'b1;
      end else begin
        out_temp_nxt = t_full[TEMP_W-1:0];
      end
    end else if (last.ovf) begin
      out_err_nxt = 1'b1;
    end else begin
      out_temp_nxt = {1'b0, last.root[DIV2_STEPS-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (last_v && en) begin
      out_valid_r <= 1'b1;
    end else if (out_req.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (last_v && en) begin
      out_temp_r <= out_temp_nxt;
      out_err_r  <= out_err_nxt;
    end
  end

  assign out_req.valid       = out_valid_r;
  assign out_req.temperature = out_temp_r;
  assign out_req.range_error = out_err_r;

  a_err_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    (out_req.valid && out_req.range_error) |->
      (out_req.temperature == TEMP_MAX || out_req.temperature == TEMP_MIN))
    else $error("range error without saturated temperature");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> ($stable(last_v) && $stable(mul_v_r) && $stable(nset_v_r)))
    else $error("chain moved while stalled");

  a_no_accept_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_req.ready && last_v) |-> !in_req.ready)
    else $error("request taken while chain is blocked");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_req.valid && in_req.ready) |=> mul_v_r)
    else $error("accepted request lost at first stage");

endmodule
`default_nettype wire

// File: src/rtd_c2t_div_cell.sv
// one restoring division step, registered, one quotient bit per cycle while en is high
`default_nettype none
module rtd_c2t_div_cell import rtd_c2t_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      en,
  input  wire logic      in_valid,
  input  wire c2t_item_t in_item,
  output logic           out_valid,
  output c2t_item_t      out_item
);

  logic            valid_r;
  c2t_item_t       item_r;
  c2t_item_t       item_nxt;
  logic [REM_W:0]  trial;
  logic [REM_W:0]  den_x;
  logic            take;

  always_comb begin
    item_nxt = in_item;
    trial    = {in_item.rem, in_item.low[LOW_W-1]};
    den_x    = (REM_W+1)'(in_item.den);
    take     = trial >= den_x;
    item_nxt.rem  = take ? REM_W'(trial - den_x) : REM_W'(trial);
    item_nxt.low  = {in_item.low[LOW_W-2:0], 1'b0};
    item_nxt.root = {in_item.root[ROOT_W-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_r <= item_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule
`default_nettype wire

// File: src/rtd_c2t_sqrt_cell.sv
// one digit of the integer square root, registered, one root bit per cycle while en is high
`default_nettype none
module rtd_c2t_sqrt_cell import rtd_c2t_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      en,
  input  wire logic      in_valid,
  input  wire c2t_item_t in_item,
  output logic           out_valid,
  output c2t_item_t      out_item
);

  logic             valid_r;
  c2t_item_t        item_r;
  c2t_item_t        item_nxt;
  logic [REM_W+1:0] part;
  logic [REM_W+1:0] trial;
  logic             take;

  always_comb begin
    item_nxt = in_item;
    part     = {in_item.rem, in_item.low[LOW_W-1:LOW_W-2]};
    trial    = (REM_W+2)'({in_item.root, 2'b01});
    take     = part >= trial;
    item_nxt.rem  = take ? REM_W'(part - trial) : REM_W'(part);
    item_nxt.low  = {in_item.low[LOW_W-3:0], 2'b00};
    item_nxt.root = {in_item.root[ROOT_W-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_r <= item_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule
`default_nettype wire

// File: src/rtd_c2t_horner_cell.sv
// one horner step of the low-range polynomial, registered
`default_nettype none
module rtd_c2t_horner_cell import rtd_c2t_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    en,
  input  wire logic signed [ACC_W-1:0] coef,
  input  wire logic                    in_valid,
  input  wire c2t_item_t               in_item,
  output logic                         out_valid,
  output c2t_item_t                    out_item
);

  logic                           valid_r;
  c2t_item_t                      item_r;
  c2t_item_t                      item_nxt;
  logic signed [ACC_W+POLY_Q:0]   prod;
  logic signed [ACC_W+POLY_Q:0]   prod_sh;

  always_comb begin
    item_nxt = in_item;
    prod     = in_item.acc * $signed({1'b0, in_item.xq[XQ_FRAC-1 -: POLY_Q]});
    prod_sh  = prod >>> POLY_Q;
    item_nxt.acc = prod_sh[ACC_W-1:0] + coef;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_r <= item_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule
`default_nettype wire
